// ===== sv/assert_macros.svh =====
// Concurrent assertion macros for the deinterleaver RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/tdi_pkg.sv =====
// Shared constants for the 16-branch time deinterleaver.
// No dependencies.
`default_nettype none
package tdi_pkg;
	localparam int SOFT_W       = 16;
	localparam int CFG_W        = 14;
	localparam int ROW_W        = 4;
	localparam int MAX_FRAG_DEF = 8192;
	localparam logic [CFG_W-1:0] FRAG_RESET = CFG_W'(8192);
	localparam logic [4:0] FILL_FRAMES = 5'd16;

	typedef logic [ROW_W-1:0] row_t;

	localparam row_t BRANCH_MAP [16] = '{
		4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
		4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
	};
endpackage
`default_nettype wire

// ===== sv/tdi_store.sv =====
// Branch store: one write and one registered read per cycle outside the
// reset sweep, which zeroes it and ignores writes. Depends on tdi_pkg.
`default_nettype none
module tdi_store
	import tdi_pkg::*;
#(
	parameter int ADDR_W = ROW_W + $clog2(MAX_FRAG_DEF)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [SOFT_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [SOFT_W-1:0] rd_data,
	output logic                   busy
);
	logic [SOFT_W-1:0] mem [2**ADDR_W];
	logic [ADDR_W-1:0] clr_addr_q;
	logic              busy_q;

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== sv/time_deinterleaver_16_branch_unit.sv =====
// 16-branch time deinterleaver for a stream of signed soft bits: top level.
// Depends on tdi_pkg, tdi_store and assert_macros.svh.
//
// Usage:
//  s_tvalid/s_tready/s_tdata carry one soft bit per item (s_tdata[15:0]).
//  m_tvalid/m_tready/m_tdata carry the deinterleaved value (m_tdata[15:0]),
//  with m_tlast set on the result of the last item of a frame.
//  cfg_valid/cfg_ready/cfg_data write the frame length (fragment size);
//  cfg_ready is always high. Write it only while the block is idle.
//  Throughput is one item per cycle while s_tready is high; an accepted item
//  passes a registered store read stage and then an output register.
//  The first 16 frames only fill the store and give no results.
//  After reset the store is zeroed, one entry per cycle, over all
//  16 * 2**ceil(log2(MAX_FRAGMENT)) entries (131072 at the default); s_tready
//  stays low meanwhile. Reset also returns the frame length to 8192.
//  When m_tready is low the output register and the read stage hold their
//  items and s_tready falls once both are full; nothing is dropped.
`default_nettype none
`include "assert_macros.svh"
module time_deinterleaver_16_branch_unit
	import tdi_pkg::*;
#(
	parameter int MAX_FRAGMENT = MAX_FRAG_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [SOFT_W-1:0] s_tdata,   // [15:0] soft_in
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [SOFT_W-1:0] m_tdata,   // [15:0] soft_out
	output logic                   m_tlast,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_W-1:0]  cfg_data
);
	localparam int COL_W  = $clog2(MAX_FRAGMENT);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int MAX_W  = $clog2(MAX_FRAGMENT + 1);
	localparam int SZ_W   = (MAX_W > CFG_W) ? MAX_W : CFG_W;
	localparam int CMP_W  = SZ_W + 1;

	logic [CFG_W-1:0]  size_q;
	logic [COL_W-1:0]  pos_q;
	row_t              row_q;
	logic [4:0]        fill_q;

	logic              valid_s1;
	logic              bypass_s1;
	logic              last_s1;
	logic [SOFT_W-1:0] soft_s1;
	logic [SOFT_W-1:0] rd_data;
	logic              store_busy;

	logic              m_valid_q;
	logic [SOFT_W-1:0] m_data_q;
	logic              m_last_q;

	logic              accept;
	logic              adv_s1;
	logic              emit;
	logic              last;
	row_t              map_off;
	row_t              rd_row;
	logic [CMP_W-1:0]  size_ext;
	logic [CMP_W-1:0]  eff_size;
	logic [CMP_W-1:0]  pos_inc;

	assign cfg_ready = 1'b1;

	always_comb begin
		size_ext = CMP_W'(size_q);
		if (size_q == '0) begin
			eff_size = CMP_W'(1);
		end else if (size_ext > CMP_W'(MAX_FRAGMENT)) begin
			eff_size = CMP_W'(MAX_FRAGMENT);
		end else begin
			eff_size = size_ext;
		end
		pos_inc = CMP_W'(pos_q) + CMP_W'(1);
		last    = (pos_inc >= eff_size);
		map_off = BRANCH_MAP[pos_q[ROW_W-1:0]];
		rd_row  = row_q + map_off;
		emit    = (fill_q == FILL_FRAMES);
	end

	assign adv_s1   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !store_busy && (!valid_s1 || adv_s1);
	assign accept   = s_tvalid && s_tready;

	// frame counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= FRAG_RESET;
			pos_q  <= '0;
			row_q  <= '0;
			fill_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
			end
			if (accept) begin
				if (last) begin
					pos_q <= '0;
					row_q <= row_q + 1'b1;
					if (!emit) begin
						fill_q <= fill_q + 1'b1;
					end
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	tdi_store #(
		.ADDR_W(ADDR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_addr ({row_q, pos_q}),
		.wr_data (s_tdata),
		.rd_en   (accept),
		.rd_addr ({rd_row, pos_q}),
		.rd_data (rd_data),
		.busy    (store_busy)
	);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= emit;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// same row read and written: take the item itself
	always_ff @(posedge clk) begin
		if (accept) begin
			bypass_s1 <= (map_off == '0);
			last_s1   <= last;
			soft_s1   <= s_tdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_data_q <= bypass_s1 ? soft_s1 : rd_data;
			m_last_q <= last_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	`ASSERT_NEVER(a_no_accept_clear, clk, arst_n, accept && store_busy, "item taken during store clear")
	`ASSERT_CLK(a_s1_hold, clk, arst_n, (valid_s1 && m_valid_q && !m_tready) |=> valid_s1, "read stage lost an item under stall")
	`ASSERT_CLK(a_row_step, clk, arst_n, (accept && last) |=> (row_q == $past(row_q) + 4'd1), "frame row did not advance at frame end")
	`ASSERT_NEVER(a_fill_sat, clk, arst_n, fill_q > FILL_FRAMES, "fill count past saturation")
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the 16-branch time deinterleaver top level.
// Depends on tdi_pkg and the RTL; a scoreboard class tracks store and frame state.
module tb_top;
	import tdi_pkg::*;

	localparam int WATCHDOG_LIMIT = 600000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int SETTLE_CYCLES  = 8;

	typedef struct {
		logic [SOFT_W-1:0] data;
		logic              last;
	} soft_result_t;

	class deinterleave_board;
		bit [SOFT_W-1:0] store [16][MAX_FRAG_DEF];
		row_t            wr_row;
		int unsigned     pos;
		int unsigned     filled;
		logic [CFG_W-1:0] frame_len;
		soft_result_t    due_q [$];
		int unsigned     inputs;
		int unsigned     checked;
		int unsigned     frame_ends;
		int unsigned     errors;

		function new();
			wr_row = '0;
			pos = 0;
			filled = 0;
			frame_len = FRAG_RESET;
			inputs = 0;
			checked = 0;
			frame_ends = 0;
			errors = 0;
		endfunction

		function void set_frame_len(logic [CFG_W-1:0] v);
			frame_len = v;
		endfunction

		function int unsigned pending();
			return due_q.size();
		endfunction

		// write first, then read the branch selected by the bit-reversed low four column bits
		function void absorb_soft(logic [SOFT_W-1:0] v);
			int unsigned  span;
			int unsigned  col;
			row_t         rd_row;
			soft_result_t r;
			span = (frame_len == 0) ? 1 :
				(frame_len > MAX_FRAG_DEF) ? MAX_FRAG_DEF : int'(frame_len);
			col = (pos >= MAX_FRAG_DEF) ? MAX_FRAG_DEF - 1 : pos;
			store[wr_row][col] = v;
			rd_row = row_t'(wr_row + BRANCH_MAP[col % 16]);
			r.data = store[rd_row][col];
			r.last = (pos + 1 >= span);
			inputs++;
			if (filled >= FILL_FRAMES)
				due_q.push_back(r);
			if (r.last) begin
				pos = 0;
				wr_row = row_t'(wr_row + 1);
				if (filled < FILL_FRAMES)
					filled++;
			end else begin
				pos++;
			end
		endfunction

		function void check_result(logic [SOFT_W-1:0] got, logic last);
			soft_result_t e;
			if (due_q.size() == 0) begin
				$error("unexpected result: soft_out=%0d frame_end=%0b", $signed(got), last);
				errors++;
				return;
			end
			e = due_q.pop_front();
			checked++;
			if (last === 1'b1)
				frame_ends++;
			if (got !== e.data) begin
				$error("soft_out: expected %0d, actual %0d", $signed(e.data), $signed(got));
				errors++;
			end
			if (last !== e.last) begin
				$error("frame_end: expected %0b, actual %0b", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [SOFT_W-1:0] s_tdata = '0;   // [15:0] soft_in
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [SOFT_W-1:0] m_tdata;        // [15:0] soft_out
	logic              m_tlast;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data = '0;

	deinterleave_board board = new();
	int unsigned burst_left = 0;
	int unsigned len_writes = 0;
	int unsigned quiet_cycles = 0;
	int unsigned stall_span = 0;
	logic [15:0] rdy_bits = '1;

	time_deinterleaver_16_branch_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// output stall pattern: rotating ready word, re-picked when its random span runs out
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_span = $urandom_range(20, 120);
			case ($urandom_range(0, 2))
				0: begin
					rdy_bits = '1;
				end
				1: begin
					rdy_bits = 16'($urandom);
				end
				default: begin
					rdy_bits = 16'h00ff;
				end
			endcase
		end
		stall_span--;
		rdy_bits = {rdy_bits[14:0], rdy_bits[15]};
		m_tready <= rdy_bits[0];
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("time_deinterleaver_16_branch_unit verification failed");
			$finish;
		end
	end

	task automatic send_soft(input logic [SOFT_W-1:0] v);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
		board.absorb_soft(v);
	endtask

	// called at the edge of the last accepted item, so s_tvalid gets one assignment
	task automatic write_frame_len(input logic [CFG_W-1:0] v);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_frame_len(v);
		len_writes++;
	endtask

	function automatic logic [SOFT_W-1:0] pick_soft();
		case ($urandom_range(0, 11))
			0: pick_soft = 16'h8000;
			1: pick_soft = 16'h7fff;
			2: pick_soft = 16'h0000;
			3: pick_soft = 16'hffff;
			default: pick_soft = 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [CFG_W-1:0] lens [12];
		logic [SOFT_W-1:0] edge_vals [6];
		lens = '{14'd2, 14'd16383, 14'd16, 14'd0, 14'd8192, 14'd5, 14'd17,
			14'($urandom_range(1, 64)), 14'($urandom_range(1, 64)), 14'd3,
			14'd8191, 14'd1};
		edge_vals = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h5555, 16'haaaa};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset length: a few items start a long frame, then the length shrinks under it
		for (int i = 0; i < 3; i++)
			send_soft(edge_vals[i]);
		write_frame_len(14'd1);
		for (int i = 0; i < 16; i++)
			send_soft(edge_vals[i % 6]);
		for (int i = 0; i < 6; i++)
			send_soft(edge_vals[i]);
		write_frame_len(14'd0);
		for (int i = 0; i < 3; i++)
			send_soft(edge_vals[5 - i]);

		foreach (lens[k]) begin
			write_frame_len(lens[k]);
			for (int i = 0; i < 75; i++)
				send_soft(pick_soft());
		end
		s_tvalid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d soft bits sent over %0d frame length settings (0 to 16383)",
			board.inputs, len_writes);
		$display("%0d results checked, %0d of them frame ends", board.checked, board.frame_ends);
		if (board.errors == 0)
			$display("time_deinterleaver_16_branch_unit verification clean");
		else
			$display("time_deinterleaver_16_branch_unit verification failed");
		$finish;
	end
endmodule
